/* src/integer_square_root_search_top_defines.svh */
// assertion macros for the square root search block
`ifndef INTEGER_SQUARE_ROOT_SEARCH_TOP_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising clock edge out of reset
`define ISRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isrs assertion failed");
// next-cycle implication
`define ISRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isrs assertion failed");
`else
`define ISRS_ASSERT_IMP(label, ante, cons)
`define ISRS_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* src/isrs_pkg.sv */
`timescale 1ns / 1ps

package isrs_pkg;

  // field widths of the stream items
  localparam int VALUE_W = 32;
  localparam int ROOT_W  = 16;

  // default width of the value that takes part in the search
  localparam int VALUE_WIDTH_DEF = 32;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MID  = 5'b00010,
    ST_SQR  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } isrs_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new value and set up the bounds
    logic calc_mid;  // register the midpoint of the bounds
    logic square;    // register the square of the midpoint
    logic update;    // compare and move one bound
    logic emit;      // move best root into the output register
    logic in_ready;  // controller can take an item
  } isrs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic range_ok;  // low bound not above high bound
  } isrs_status_t;

endpackage

/* src/isrs_datapath.sv */
`timescale 1ns / 1ps

module isrs_datapath
  import isrs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                clk_i,
  input  isrs_cmd_t           cmd_i,
  input  logic [VALUE_W-1:0]  value_i,
  output isrs_status_t        status_o,
  output logic [ROOT_W-1:0]   root_o
);

  localparam int HALF = (VALUE_WIDTH + 1) / 2;
  localparam int RW   = HALF + 1;
  localparam int SQW  = 2 * HALF;

  logic [VALUE_WIDTH-1:0] held_q;
  logic [RW-1:0]          low_q, high_q;
  logic [HALF-1:0]        mid_q, best_q;
  logic [SQW-1:0]         sq_q;

  logic [VALUE_WIDTH+VALUE_W-1:0] value_ext;
  logic [VALUE_WIDTH-1:0]         value_m;
  logic [VALUE_WIDTH+SQW-1:0]     new_ext;
  logic [VALUE_WIDTH+SQW-1:0]     held_ext;
  logic [SQW-1:0]                 new_cmp, held_cmp, lim_cmp;
  logic [RW:0]                    mid_sum;
  logic [HALF+ROOT_W-1:0]         best_ext;

  // keep only the low VALUE_WIDTH bits of the incoming value
  assign value_ext = {{VALUE_WIDTH{1'b0}}, value_i};
  assign value_m   = value_ext[VALUE_WIDTH-1:0];

  // compare-width views
  assign new_ext  = {{SQW{1'b0}}, value_m};
  assign held_ext = {{SQW{1'b0}}, held_q};
  assign new_cmp  = new_ext[SQW-1:0];
  assign held_cmp = held_ext[SQW-1:0];
  assign lim_cmp  = {{HALF{1'b0}}, {HALF{1'b1}}};

  assign mid_sum  = {1'b0, low_q} + {1'b0, high_q};

  // search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q <= value_m;
      low_q  <= RW'(1);
      best_q <= '0;
      if (new_cmp < lim_cmp) begin
        high_q <= new_cmp[RW-1:0];
      end else begin
        high_q <= lim_cmp[RW-1:0];
      end
    end
    if (cmd_i.calc_mid) begin
      mid_q <= mid_sum[HALF:1];
    end
    if (cmd_i.square) begin
      sq_q <= SQW'(mid_q) * SQW'(mid_q);
    end
    if (cmd_i.update) begin
      if (sq_q <= held_cmp) begin
        best_q <= mid_q;
        low_q  <= {1'b0, mid_q} + RW'(1);
      end else begin
        high_q <= {1'b0, mid_q} - RW'(1);
      end
    end
  end

  assign status_o.range_ok = (low_q <= high_q);

  // low 16 bits of the best root
  assign best_ext = {{ROOT_W{1'b0}}, best_q};
  assign root_o   = best_ext[ROOT_W-1:0];

endmodule

/* src/isrs_ctrl.sv */
`timescale 1ns / 1ps

module isrs_ctrl
  import isrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         out_free_i,
  input  isrs_status_t status_i,
  output isrs_cmd_t    cmd_o
);

  isrs_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MID;
        end
      end
      ST_MID: begin
        if (status_i.range_ok) begin
          cmd_o.calc_mid = 1'b1;
          state_d        = ST_SQR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_MID;
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/integer_square_root_search_top.sv */
`timescale 1ns / 1ps
// Floor square root by binary search. Each input item carries a 32-bit unsigned value, of
// which the low VALUE_WIDTH bits are used; each result item carries the 16-bit floor root.
// One item is worked on at a time. A search step registers the midpoint, squares it on the
// one multiplier, then compares and updates a bound, and a search needs at most
// H = (VALUE_WIDTH+1)/2 steps; zero needs none. The result sits in an output register,
// so the next item is taken as soon as the result is loaded there, even before it is read.

`include "integer_square_root_search_top_defines.svh"

module integer_square_root_search_top
  import isrs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ROOT_W-1:0]  m_axis_tdata    // [15:0] root
);

  isrs_cmd_t          cmd;
  isrs_status_t       status;
  logic [ROOT_W-1:0]  root;
  logic               out_valid_q;
  logic [ROOT_W-1:0]  out_root_q;
  logic               out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  isrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  isrs_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .value_i  (s_axis_tdata),
    .status_o (status),
    .root_o   (root)
  );

  // output register, valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register, payload
  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_root_q <= root;
    end
  end

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_root_q;

  // controller busy right after taking an item
  `ISRS_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a result is only loaded into a free output slot
  `ISRS_ASSERT_IMP(a_emit_into_free_slot, cmd.emit, out_free)
  // no search work while waiting for an item
  `ISRS_ASSERT_IMP(a_idle_no_work, s_axis_tready, !cmd.square && !cmd.update && !cmd.emit)

endmodule
